### hw/rtl/vmu_pkg.sv
package vmu_pkg;

  localparam int FracBitsDef = 16;
  localparam int DataW       = 32;
  localparam int Lanes       = 4;
  localparam int SumW        = 65;
  localparam int RootW       = 33;
  localparam int NumW        = 97;
  localparam int QuotW       = 32;

  localparam logic [2:0] DimReset = 3'd4;
  localparam logic [2:0] DimMin   = 3'd2;
  localparam logic [2:0] DimMax   = 3'd4;
  localparam logic [2:0] DimCross = 3'd3;

  localparam logic [2:0] CmdMag   = 3'd0;
  localparam logic [2:0] CmdDot   = 3'd1;
  localparam logic [2:0] CmdCross = 3'd2;
  localparam logic [2:0] CmdNorm  = 3'd3;
  localparam logic [2:0] CmdProj  = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StDivZero = 2'd1;
  localparam logic [1:0] StCross   = 2'd2;
  localparam logic [1:0] StSat     = 2'd3;

  typedef logic [Lanes-1:0][DataW-1:0] vmu_vec_t;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
  } vmu_req_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic signed [31:0] scalar;
    logic        [1:0]  status;
  } vmu_rsp_t;

  // data carried down the pipeline
  typedef struct packed {
    logic [2:0]       cmd;
    logic [1:0]       status;
    logic             sat;
    logic [DataW-1:0] scalar;
    vmu_vec_t         r;
    logic [SumW-1:0]  s;
    vmu_vec_t         a_mag;
    logic [Lanes-1:0] a_neg;
    vmu_vec_t         b_mag;
    logic [Lanes-1:0] b_neg;
    logic [SumW-1:0]  dot_mag;
    logic             dot_neg;
    logic [SumW-1:0]  bb;
    logic [RootW-1:0] root;
  } vmu_pipe_t;

  // {flag, value}: clamp a magnitude with sign to 32-bit two's complement
  function automatic logic [DataW:0] sat32(input logic [NumW-1:0] mag, input logic neg);
    logic [NumW-1:0]  limit;
    logic [DataW-1:0] m;
    logic             flag;
    limit = neg ? NumW'(33'h080000000) : NumW'(32'h7fffffff);
    flag  = mag > limit;
    m     = flag ? limit[DataW-1:0] : mag[DataW-1:0];
    return {flag, neg ? (~m + 32'd1) : m};
  endfunction

endpackage

### hw/rtl/vmu_front.sv
module vmu_front #(
  parameter int FRAC_BITS = vmu_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  vmu_pkg::vmu_req_t  req_i,
  input  logic [2:0]         dim_i,
  output logic               valid_o,
  output vmu_pkg::vmu_pipe_t pipe_o
);
  import vmu_pkg::*;

  logic [2:0]         deff;
  logic signed [31:0] am [Lanes];
  logic signed [31:0] bm [Lanes];

  // stage 1: products
  logic               v1_q;
  logic [2:0]         cmd1_q;
  logic               d3_1_q;
  logic signed [31:0] am1_q [Lanes];
  logic signed [31:0] bm1_q [Lanes];
  logic signed [63:0] paa1_q [Lanes];
  logic signed [63:0] pab1_q [Lanes];
  logic signed [63:0] pbb1_q [Lanes];
  logic signed [63:0] pcr1_q [6];

  // stage 2: sums
  logic               v2_q;
  logic [2:0]         cmd2_q;
  logic               d3_2_q;
  logic signed [31:0] am2_q [Lanes];
  logic signed [31:0] bm2_q [Lanes];
  logic [SumW-1:0]    s2_q;
  logic signed [65:0] dot2_q;
  logic [SumW-1:0]    bb2_q;
  logic signed [64:0] cr2_q [3];

  // stage 3: magnitudes and early results
  logic               v3_q;
  vmu_pipe_t          pipe_d;
  vmu_pipe_t          pipe_q;
  logic               dot_neg;
  logic [SumW-1:0]    dot_mag;
  logic [DataW:0]     dres;
  logic [2:0]         cneg;
  logic [63:0]        cmag [3];
  logic [DataW:0]     cres [3];

  always_comb begin
    if (dim_i inside {[3'd0:3'd1]}) begin
      deff = DimMin;
    end else if (dim_i inside {[3'd5:3'd7]}) begin
      deff = DimMax;
    end else begin
      deff = dim_i;
    end
    am[0] = req_i.a_x;
    am[1] = req_i.a_y;
    am[2] = req_i.a_z;
    am[3] = req_i.a_w;
    bm[0] = req_i.b_x;
    bm[1] = req_i.b_y;
    bm[2] = req_i.b_z;
    bm[3] = req_i.b_w;
    for (int i = 0; i < Lanes; i++) begin
      if (3'(i) >= deff) begin
        am[i] = '0;
        bm[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q <= req_i.cmd;
      d3_1_q <= deff == DimCross;
      for (int i = 0; i < Lanes; i++) begin
        am1_q[i]  <= am[i];
        bm1_q[i]  <= bm[i];
        paa1_q[i] <= am[i] * am[i];
        pab1_q[i] <= am[i] * bm[i];
        pbb1_q[i] <= bm[i] * bm[i];
      end
      pcr1_q[0] <= am[1] * bm[2];
      pcr1_q[1] <= am[2] * bm[1];
      pcr1_q[2] <= am[2] * bm[0];
      pcr1_q[3] <= am[0] * bm[2];
      pcr1_q[4] <= am[0] * bm[1];
      pcr1_q[5] <= am[1] * bm[0];

      cmd2_q <= cmd1_q;
      d3_2_q <= d3_1_q;
      am2_q  <= am1_q;
      bm2_q  <= bm1_q;
      s2_q   <= SumW'($unsigned(paa1_q[0])) + SumW'($unsigned(paa1_q[1]))
              + SumW'($unsigned(paa1_q[2])) + SumW'($unsigned(paa1_q[3]));
      bb2_q  <= SumW'($unsigned(pbb1_q[0])) + SumW'($unsigned(pbb1_q[1]))
              + SumW'($unsigned(pbb1_q[2])) + SumW'($unsigned(pbb1_q[3]));
      dot2_q <= 66'(pab1_q[0]) + 66'(pab1_q[1]) + 66'(pab1_q[2]) + 66'(pab1_q[3]);
      cr2_q[0] <= 65'(pcr1_q[0]) - 65'(pcr1_q[1]);
      cr2_q[1] <= 65'(pcr1_q[2]) - 65'(pcr1_q[3]);
      cr2_q[2] <= 65'(pcr1_q[4]) - 65'(pcr1_q[5]);

      pipe_q <= pipe_d;
    end
  end

  always_comb begin
    pipe_d        = '0;
    pipe_d.cmd    = cmd2_q;
    pipe_d.status = StOk;
    pipe_d.s      = s2_q;
    pipe_d.bb     = bb2_q;
    dot_neg       = dot2_q[65];
    dot_mag       = SumW'(dot_neg ? -dot2_q : dot2_q);
    pipe_d.dot_neg = dot_neg;
    pipe_d.dot_mag = dot_mag;
    dres = sat32(NumW'(dot_mag >> FRAC_BITS), dot_neg);
    for (int i = 0; i < Lanes; i++) begin
      pipe_d.a_neg[i] = am2_q[i][31];
      pipe_d.b_neg[i] = bm2_q[i][31];
      pipe_d.a_mag[i] = am2_q[i][31] ? 32'(-am2_q[i]) : 32'(am2_q[i]);
      pipe_d.b_mag[i] = bm2_q[i][31] ? 32'(-bm2_q[i]) : 32'(bm2_q[i]);
    end
    for (int i = 0; i < 3; i++) begin
      cneg[i] = cr2_q[i][64];
      cmag[i] = 64'(cneg[i] ? -cr2_q[i] : cr2_q[i]);
      cres[i] = sat32(NumW'(cmag[i] >> FRAC_BITS), cneg[i]);
    end
    case (cmd2_q)
      CmdDot: begin
        pipe_d.scalar = dres[DataW-1:0];
        pipe_d.sat    = dres[DataW];
      end
      CmdCross: begin
        if (!d3_2_q) begin
          pipe_d.status = StCross;
        end else begin
          for (int i = 0; i < 3; i++) begin
            pipe_d.r[i] = cres[i][DataW-1:0];
          end
          pipe_d.sat = cres[0][DataW] | cres[1][DataW] | cres[2][DataW];
        end
      end
      CmdProj: begin
        if (bb2_q == '0) begin
          pipe_d.status = StDivZero;
        end
      end
      default: ;
    endcase
  end

  assign valid_o = v3_q;
  assign pipe_o  = pipe_q;

endmodule

### hw/rtl/vmu_sqrt.sv
module vmu_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  vmu_pkg::vmu_pipe_t pipe_i,
  output logic               valid_o,
  output vmu_pkg::vmu_pipe_t pipe_o
);
  import vmu_pkg::*;

  localparam int Steps = RootW;
  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 2;

  logic            v_q   [Steps];
  vmu_pipe_t       p_q   [Steps];
  logic [RadW-1:0] rad_q [Steps];
  logic [RemW-1:0] rem_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic            pv;
    vmu_pipe_t       pp;
    logic [RadW-1:0] prad;
    logic [RemW-1:0] prem;
    logic [RemW+1:0] cat;
    logic [RemW+1:0] trial;
    logic            ge;
    vmu_pipe_t       p_d;

    if (k == 0) begin : g_in
      assign pv   = valid_i;
      assign pp   = pipe_i;
      assign prad = RadW'(pipe_i.s);
      assign prem = '0;
    end else begin : g_prev
      assign pv   = v_q[k-1];
      assign pp   = p_q[k-1];
      assign prad = rad_q[k-1];
      assign prem = rem_q[k-1];
    end

    always_comb begin
      cat      = {prem, prad[RadW-1 -: 2]};
      trial    = (RemW+2)'({pp.root, 2'b01});
      ge       = cat >= trial;
      p_d      = pp;
      p_d.root = {pp.root[RootW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k]   <= p_d;
        rad_q[k] <= {prad[RadW-3:0], 2'b00};
        rem_q[k] <= ge ? RemW'(cat - trial) : RemW'(cat);
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign pipe_o  = p_q[Steps-1];

endmodule

### hw/rtl/vmu_div.sv
module vmu_div #(
  parameter int FRAC_BITS = vmu_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  vmu_pkg::vmu_pipe_t pipe_i,
  output logic               valid_o,
  output vmu_pkg::vmu_rsp_t  rsp_o
);
  import vmu_pkg::*;

  localparam int Steps = QuotW;

  // prep stages
  logic            v1_q, v2_q, v3_q;
  vmu_pipe_t       p1_q, p2_q, p3_q;
  logic [63:0]     lo1_q  [Lanes];
  logic [SumW-1:0] hi1_q  [Lanes];
  logic [NumW-1:0] num2_q [Lanes];
  logic [SumW-1:0] den2_q;
  logic [SumW-1:0] rem3_q [Lanes];
  logic [QuotW-1:0] nq3_q [Lanes];
  logic [Lanes-1:0] ovf3_q;
  logic [SumW-1:0] den3_q;
  logic            proj1;

  // divide steps
  logic             v_q    [Steps];
  vmu_pipe_t        p_q    [Steps];
  logic [SumW-1:0]  den_q  [Steps];
  logic [Lanes-1:0] ovf_q  [Steps];
  logic [SumW-1:0]  rem_q  [Steps][Lanes];
  logic [QuotW-1:0] nq_q   [Steps][Lanes];

  // final
  logic             vo_q;
  vmu_rsp_t         rsp_q;
  vmu_pipe_t        pf;
  logic [QuotW-1:0] qf   [Lanes];
  logic [Lanes-1:0] ovff;
  logic [1:0]       st;
  logic             sat;
  vmu_vec_t         r;
  logic [DataW-1:0] scalar;
  logic [DataW:0]   lres [Lanes];
  logic [DataW:0]   mres;
  logic [NumW-1:0]  lmag;
  logic             lneg;

  assign proj1 = p1_q.cmd == CmdProj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= pipe_i;
      for (int i = 0; i < Lanes; i++) begin
        lo1_q[i] <= pipe_i.dot_mag[31:0] * pipe_i.b_mag[i];
        hi1_q[i] <= pipe_i.dot_mag[SumW-1:32] * pipe_i.b_mag[i];
      end

      p2_q   <= p1_q;
      den2_q <= proj1 ? p1_q.bb : SumW'(p1_q.root);
      for (int i = 0; i < Lanes; i++) begin
        num2_q[i] <= proj1 ? ({hi1_q[i], 32'd0} + NumW'(lo1_q[i]))
                           : (NumW'(p1_q.a_mag[i]) << FRAC_BITS);
      end

      p3_q   <= p2_q;
      den3_q <= den2_q;
      for (int i = 0; i < Lanes; i++) begin
        ovf3_q[i] <= num2_q[i][NumW-1:QuotW] >= den2_q;
        rem3_q[i] <= num2_q[i][NumW-1:QuotW];
        nq3_q[i]  <= num2_q[i][QuotW-1:0];
      end

      rsp_q <= '{r_x: r[0], r_y: r[1], r_z: r[2], r_w: r[3], scalar: scalar, status: st};
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic             pv;
    vmu_pipe_t        pp;
    logic [SumW-1:0]  pden;
    logic [Lanes-1:0] povf;
    logic [SumW-1:0]  prem [Lanes];
    logic [QuotW-1:0] pnq  [Lanes];
    logic [SumW:0]    cat  [Lanes];
    logic             ge   [Lanes];

    if (k == 0) begin : g_in
      assign pv   = v3_q;
      assign pp   = p3_q;
      assign pden = den3_q;
      assign povf = ovf3_q;
      assign prem = rem3_q;
      assign pnq  = nq3_q;
    end else begin : g_prev
      assign pv   = v_q[k-1];
      assign pp   = p_q[k-1];
      assign pden = den_q[k-1];
      assign povf = ovf_q[k-1];
      assign prem = rem_q[k-1];
      assign pnq  = nq_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < Lanes; i++) begin
        cat[i] = {prem[i], pnq[i][QuotW-1]};
        ge[i]  = cat[i] >= {1'b0, pden};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k]   <= pp;
        den_q[k] <= pden;
        ovf_q[k] <= povf;
        for (int i = 0; i < Lanes; i++) begin
          rem_q[k][i] <= ge[i] ? SumW'(cat[i] - {1'b0, pden}) : SumW'(cat[i]);
          nq_q[k][i]  <= {pnq[i][QuotW-2:0], ge[i]};
        end
      end
    end
  end

  always_comb begin
    pf     = p_q[Steps-1];
    qf     = nq_q[Steps-1];
    ovff   = ovf_q[Steps-1];
    st     = pf.status;
    sat    = pf.sat;
    r      = pf.r;
    scalar = pf.scalar;
    mres   = sat32(NumW'(pf.root), 1'b0);
    lmag   = '0;
    lneg   = 1'b0;
    for (int i = 0; i < Lanes; i++) begin
      lneg    = (pf.cmd == CmdProj) ? (pf.dot_neg ^ pf.b_neg[i]) : pf.a_neg[i];
      lmag    = ovff[i] ? (NumW'(1) << QuotW) : NumW'(qf[i]);
      lres[i] = sat32(lmag, lneg);
    end
    case (pf.cmd)
      CmdMag: begin
        scalar = mres[DataW-1:0];
        sat    = mres[DataW];
      end
      CmdNorm: begin
        if (pf.root == '0) begin
          st = StDivZero;
        end else begin
          for (int i = 0; i < Lanes; i++) begin
            r[i] = lres[i][DataW-1:0];
            sat  = sat | lres[i][DataW];
          end
        end
      end
      CmdProj: begin
        if (pf.status != StDivZero) begin
          for (int i = 0; i < Lanes; i++) begin
            r[i] = lres[i][DataW-1:0];
            sat  = sat | lres[i][DataW];
          end
        end
      end
      default: ;
    endcase
    if (st == StOk && sat) begin
      st = StSat;
    end
  end

  assign valid_o = vo_q;
  assign rsp_o   = rsp_q;

endmodule

### hw/rtl/vmu_obuf.sv
module vmu_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  vmu_pkg::vmu_rsp_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output vmu_pkg::vmu_rsp_t data_o
);
  import vmu_pkg::*;

  vmu_rsp_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign push    = valid_i && !full_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

### hw/rtl/vector_math_unit_top.sv
// Vector math unit: magnitude, dot, cross, normalize and projection over two
// vectors of up to four signed fixed-point elements. One request is accepted
// every clock cycle while a full output buffer does not stall the pipeline; a
// request's result passes through the 33-step square root pipeline, the
// 32-step divide pipeline and the multiply/sum/prep stages around them. A
// two-entry output buffer lets the pipeline keep moving while a result
// waits. The dimension register may only be written while the unit is idle.
module vector_math_unit_top #(
  parameter int FRAC_BITS = vmu_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vmu_pkg::vmu_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vmu_pkg::vmu_rsp_t out_rsp_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i
);
  import vmu_pkg::*;

  logic      [2:0] dim_q;
  logic            en;
  logic            fr_v, sq_v, dv_v, ob_full;
  vmu_pipe_t       fr_p, sq_p;
  vmu_rsp_t        dv_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DimReset;
    end else if (cfg_we_i) begin
      dim_q <= cfg_wdata_i;
    end
  end

  assign en         = !dv_v || !ob_full;
  assign in_ready_o = en;

  vmu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .req_i(in_req_i),
    .dim_i(dim_q), .valid_o(fr_v), .pipe_o(fr_p)
  );

  vmu_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_v), .pipe_i(fr_p),
    .valid_o(sq_v), .pipe_o(sq_p)
  );

  vmu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v), .pipe_i(sq_p),
    .valid_o(dv_v), .rsp_o(dv_rsp)
  );

  vmu_obuf u_obuf (
    .clk_i, .rst_ni, .valid_i(dv_v), .data_i(dv_rsp), .full_o(ob_full),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .data_o(out_rsp_o)
  );

endmodule

### hw/rtl/vmu_checker.sv
module vmu_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input vmu_pkg::vmu_rsp_t out_rsp_o
);
  import vmu_pkg::*;

  logic rzero;
  assign rzero = out_rsp_o.r_x == '0 && out_rsp_o.r_y == '0 &&
                 out_rsp_o.r_z == '0 && out_rsp_o.r_w == '0;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped or changed while stalled");

  a_divzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == StDivZero |-> rzero && out_rsp_o.scalar == '0)
    else $error("divide status with nonzero result");

  a_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == StCross |-> rzero && out_rsp_o.scalar == '0)
    else $error("cross dimension status with nonzero result");

  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.scalar != '0 |-> rzero)
    else $error("scalar and vector result both nonzero");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind vector_math_unit_top vmu_checker u_vmu_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vmu_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  vmu_req_t in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  vmu_rsp_t out_rsp_o;
  logic     cfg_we_i = 1'b0;
  logic [2:0] cfg_wdata_i = DimReset;

  vector_math_unit_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_rsp_o(out_rsp_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  vmu_req_t   pending_reqs[$];
  vmu_rsp_t   expected_rsps[$];
  logic [2:0] cur_dim = DimReset;
  int         tx_idle = 0;
  int         rx_stall = 0;
  logic       long_hold_go = 1'b0;
  logic       long_hold_done = 1'b0;
  int         hold_left = 0;
  logic       in_fire = 1'b0;
  int         errors = 0;
  int         cycles = 0;

  function automatic logic [127:0] isqrt_floor(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    if (s[127:64] != 0) return 128'(1) << 32;
    for (int bit_i = 31; bit_i >= 0; bit_i--) begin
      c = r | (128'(1) << bit_i);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  // {flag, value}
  function automatic logic [32:0] clamp32(input logic [127:0] mag, input logic neg);
    logic [127:0] limit;
    logic [31:0]  m;
    logic         flag;
    limit = neg ? 128'h80000000 : 128'h7fffffff;
    flag  = mag > limit;
    m     = flag ? limit[31:0] : mag[31:0];
    return {flag, neg ? (~m + 32'd1) : m};
  endfunction

  function automatic logic [32:0] shift_clamp(input logic signed [127:0] v);
    logic [127:0] mag;
    mag = (v < 0) ? -v : v;
    return clamp32(mag >> FracBitsDef, v < 0);
  endfunction

  function automatic vmu_rsp_t predict_vmu(input vmu_req_t req, input logic [2:0] dim_reg);
    logic signed [127:0] a[4];
    logic signed [127:0] b[4];
    logic signed [127:0] s, dot, bb;
    logic [127:0] m, q, dm, bm;
    logic [31:0]  res[6];
    logic [32:0]  c;
    logic [1:0]   st;
    logic         sat, dneg;
    int           d;
    vmu_rsp_t     rsp;
    d = (dim_reg < DimMin) ? 2 : (dim_reg > DimMax) ? 4 : int'(dim_reg);
    a[0] = req.a_x; a[1] = req.a_y; a[2] = req.a_z; a[3] = req.a_w;
    b[0] = req.b_x; b[1] = req.b_y; b[2] = req.b_z; b[3] = req.b_w;
    s = 0; dot = 0; bb = 0; sat = 0; st = StOk;
    for (int i = 0; i < 6; i++) res[i] = '0;
    for (int i = 0; i < 4; i++) begin
      if (i >= d) begin
        a[i] = 0; b[i] = 0;
      end
      s   = s + a[i] * a[i];
      dot = dot + a[i] * b[i];
      bb  = bb + b[i] * b[i];
    end
    case (req.cmd)
      CmdMag: begin
        c = clamp32(isqrt_floor(s), 1'b0); sat |= c[32]; res[4] = c[31:0];
      end
      CmdDot: begin
        c = shift_clamp(dot); sat |= c[32]; res[4] = c[31:0];
      end
      CmdCross: begin
        if (d != 3) st = StCross;
        else begin
          c = shift_clamp(a[1] * b[2] - a[2] * b[1]); sat |= c[32]; res[0] = c[31:0];
          c = shift_clamp(a[2] * b[0] - a[0] * b[2]); sat |= c[32]; res[1] = c[31:0];
          c = shift_clamp(a[0] * b[1] - a[1] * b[0]); sat |= c[32]; res[2] = c[31:0];
        end
      end
      CmdNorm: begin
        m = isqrt_floor(s);
        if (m == 0) st = StDivZero;
        else for (int i = 0; i < 4; i++) begin
          q = (((a[i] < 0) ? -a[i] : a[i]) << FracBitsDef) / m;
          c = clamp32(q, a[i] < 0); sat |= c[32]; res[i] = c[31:0];
        end
      end
      CmdProj: begin
        if (bb == 0) st = StDivZero;
        else begin
          dneg = dot < 0;
          dm = dneg ? -dot : dot;
          for (int i = 0; i < 4; i++) begin
            bm = (b[i] < 0) ? -b[i] : b[i];
            q = (dm * bm) / bb;
            c = clamp32(q, (dneg ^ (b[i] < 0)) && q != 0); sat |= c[32]; res[i] = c[31:0];
          end
        end
      end
      default: ;
    endcase
    if (st == StOk && sat) st = StSat;
    rsp.r_x = res[0]; rsp.r_y = res[1]; rsp.r_z = res[2]; rsp.r_w = res[3];
    rsp.scalar = res[4]; rsp.status = st;
    return rsp;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle) begin
        in_req_i   <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver; the long hold-off lets the pipe back up into the input
  always @(negedge clk_i) begin
    if (long_hold_go && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall);
    end
  end

  always @(posedge clk_i) begin
    vmu_rsp_t e;
    in_fire = in_valid_i && in_ready_o;
    if (in_fire) expected_rsps.push_back(predict_vmu(in_req_i, cur_dim));
    if (out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %h", out_rsp_o);
      end else begin
        e = expected_rsps.pop_front();
        if (e.r_x !== out_rsp_o.r_x || e.r_y !== out_rsp_o.r_y || e.r_z !== out_rsp_o.r_z ||
            e.r_w !== out_rsp_o.r_w || e.scalar !== out_rsp_o.scalar ||
            e.status !== out_rsp_o.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp r=%h %h %h %h s=%h st=%0d got r=%h %h %h %h s=%h st=%0d",
                     e.r_x, e.r_y, e.r_z, e.r_w, e.scalar, e.status,
                     out_rsp_o.r_x, out_rsp_o.r_y, out_rsp_o.r_z, out_rsp_o.r_w,
                     out_rsp_o.scalar, out_rsp_o.status);
        end
      end
    end
    cycles++;
    if (cycles > 400000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return 32'($urandom_range(32'h200000)) - 32'h100000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [2:0] cmd, input logic [31:0] ax, ay, az, aw,
                         input logic [31:0] bx, by, bz, bw);
    vmu_req_t r;
    r.cmd = cmd; r.a_x = ax; r.a_y = ay; r.a_z = az; r.a_w = aw;
    r.b_x = bx; r.b_y = by; r.b_z = bz; r.b_w = bw;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(input int n);
    logic [2:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      add_req(cmd, rand_elem(), rand_elem(), rand_elem(), rand_elem(),
              rand_elem(), rand_elem(), rand_elem(), rand_elem());
    end
  endtask

  task automatic drain_and_write(input logic [2:0] dim);
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0);
    repeat (80) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dim;
    cur_dim = dim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idle(input int mode);
    case (mode % 4)
      0: begin tx_idle = 0;  rx_stall = 0;  end
      1: begin tx_idle = 61; rx_stall = 0;  end
      2: begin tx_idle = 0;  rx_stall = 61; end
      default: begin tx_idle = 6; rx_stall = 6; end
    endcase
  endtask

  initial begin
    logic [2:0] dims[8];
    rst_ni = 1'b0;
    dims = '{3'd4, 3'd2, 3'd0, 3'd7, 3'd5, 3'd1, 3'd3, 3'd4};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    drain_and_write(DimCross);
    add_req(CmdMag, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0);
    add_req(CmdMag, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0);
    add_req(CmdDot, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    add_req(CmdDot, 32'h80000000, 32'h80000000, 32'h80000000, 0,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    add_req(CmdCross, 32'h80000000, 32'h7fffffff, 32'h80000000, 0,
            32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    add_req(CmdCross, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0);
    add_req(CmdNorm, 0, 0, 0, 32'h7fffffff, 1, 2, 3, 4);
    add_req(CmdNorm, 32'h30000, 32'hfffc0000, 0, 0, 0, 0, 0, 0);
    add_req(CmdNorm, 1, 0, 0, 0, 0, 0, 0, 0);
    add_req(CmdProj, 32'h10000, 32'h20000, 32'h30000, 0, 0, 0, 0, 32'h10000);
    add_req(CmdProj, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1, 0, 0, 0);
    add_req(CmdProj, 32'h80000000, 32'h80000000, 0, 0, 32'h10000, 32'hffff0000, 0, 0);
    add_req(3'd5, '1, '1, '1, '1, '1, '1, '1, '1);
    add_req(3'd6, 1, 2, 3, 4, 5, 6, 7, 8);
    add_req(3'd7, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
    add_req(CmdMag, 0, 0, 0, 0, 0, 0, 0, 0);
    add_req(CmdDot, 32'hffffffff, 1, 0, 0, 1, 32'hffffffff, 0, 0);
    for (int p = 0; p < 8; p++) begin
      drain_and_write(dims[p]);
      set_idle(p);
      if (p == 2) begin
        long_hold_go = 1'b1;
        tx_idle = 0;
      end
      add_random(50);
    end
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0);
    repeat (100) @(negedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
